>>> rtl/pswc_pkg.sv
// Shared types and constants for the prefix/suffix word counter.
package pswc_pkg;

    localparam int MAX_WORDS_DEF = 256;
    localparam int MAX_LEN_DEF   = 32;

    // command queue between front and back
    localparam int CMD_DEPTH = 4;

    localparam int               COUNT_W   = 9;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    localparam logic [1:0] STATUS_OK         = 2'd0;
    localparam logic [1:0] STATUS_QUERY_LONG = 2'd1;
    localparam logic [1:0] STATUS_DROPPED    = 2'd2;

    localparam logic ACTION_LOAD  = 1'b0;
    localparam logic ACTION_QUERY = 1'b1;

    typedef enum logic [1:0] {
        OP_LOAD,
        OP_QUERY,
        OP_SCAN
    } op_t;

    typedef struct packed {
        op_t        op;
        logic       has_char;
        logic       last;
        logic [7:0] ch;
    } cmd_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_FETCH,
        S_EVAL,
        S_READ,
        S_CMP,
        S_POST
    } state_t;

endpackage

>>> rtl/pswc_front.sv
// Front end: classifies incoming requests and queues them for the back end.
module pswc_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    output logic            full,
    input  logic            action,
    input  logic [7:0]      char_code,
    input  logic            has_char,
    input  logic            last,
    output logic            cmd_valid,
    input  logic            cmd_pop,
    output pswc_pkg::cmd_t  cmd
);

    localparam int PW = (pswc_pkg::CMD_DEPTH > 1) ? $clog2(pswc_pkg::CMD_DEPTH) : 1;
    localparam int NW = $clog2(pswc_pkg::CMD_DEPTH + 1);

    pswc_pkg::cmd_t q_reg [pswc_pkg::CMD_DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0]  fill_reg, fill_next;
    pswc_pkg::cmd_t in_cmd;
    logic           do_push;
    logic           do_pop;

    always_comb
    begin
        in_cmd.has_char = has_char;
        in_cmd.last     = last;
        in_cmd.ch       = char_code;
        if (action == pswc_pkg::ACTION_LOAD)
        begin
            in_cmd.op = pswc_pkg::OP_LOAD;
        end
        else if (last)
        begin
            in_cmd.op = pswc_pkg::OP_SCAN;
        end
        else
        begin
            in_cmd.op = pswc_pkg::OP_QUERY;
        end
    end

    assign full      = (fill_reg == NW'(pswc_pkg::CMD_DEPTH));
    assign cmd_valid = (fill_reg != '0);
    assign cmd       = q_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = cmd_pop && cmd_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(pswc_pkg::CMD_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(pswc_pkg::CMD_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

>>> rtl/pswc_back.sv
// Back end: word/query stores, scan sequencer and result register.
module pswc_back #(
    parameter int MAX_WORDS = pswc_pkg::MAX_WORDS_DEF,
    parameter int MAX_LEN   = pswc_pkg::MAX_LEN_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_valid,
    output logic                          cmd_pop,
    input  pswc_pkg::cmd_t                cmd,
    output logic                          empty,
    input  logic                          pop,
    output logic [pswc_pkg::COUNT_W-1:0]  match_count,
    output logic [1:0]                    status
);

    localparam int CW    = $clog2(MAX_WORDS + 1);
    localparam int SW    = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
    localparam int LW    = $clog2(MAX_LEN + 1);
    localparam int QW    = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int DEPTH = MAX_WORDS * MAX_LEN;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW    = pswc_pkg::COUNT_W;

    // memories
    logic [7:0]  word_mem [DEPTH];
    logic [LW:0] len_mem  [MAX_WORDS];    // {too_long, length}
    logic [7:0]  qry_mem  [MAX_LEN];

    logic [7:0]  head_ch_reg, tail_ch_reg, qry_ch_reg;
    logic [LW:0] len_rd_reg;

    pswc_pkg::state_t state_reg, state_next;
    logic [CW-1:0] stored_reg, stored_next;
    logic [AW-1:0] wr_base_reg, wr_base_next;
    logic [LW-1:0] load_len_reg, load_len_next;
    logic          load_ovf_reg, load_ovf_next;
    logic [LW-1:0] qlen_reg, qlen_next;
    logic          qovf_reg, qovf_next;
    logic          dropped_reg, dropped_next;
    logic [CW-1:0] slot_reg, slot_next;
    logic [AW-1:0] base_reg, base_next;
    logic [AW-1:0] head_reg, head_next;
    logic [AW-1:0] tail_reg, tail_next;
    logic [LW-1:0] k_reg, k_next;
    logic [NW-1:0] cnt_reg, cnt_next;
    logic [1:0]    res_status_reg, res_status_next;
    logic          out_valid_reg, out_valid_next;
    logic [NW-1:0] out_count_reg, out_count_next;
    logic [1:0]    out_status_reg, out_status_next;

    logic          wc_we;
    logic [AW-1:0] wc_addr;
    logic          len_we;
    logic [LW:0]   len_data;
    logic          q_we;
    logic          room;
    logic          fits;
    logic [LW-1:0] len_after;
    logic          ovf_after;
    logic          advance;
    logic [LW-1:0] rd_len;
    logic          rd_long;

    assign empty       = !out_valid_reg;
    assign match_count = out_count_reg;
    assign status      = out_status_reg;
    assign rd_len      = len_rd_reg[LW-1:0];
    assign rd_long     = len_rd_reg[LW];

    assign room      = (stored_reg < CW'(MAX_WORDS));
    assign fits      = (load_len_reg < LW'(MAX_LEN));
    assign len_after = (cmd.has_char && fits) ? load_len_reg + 1'b1 : load_len_reg;
    assign ovf_after = load_ovf_reg || (cmd.has_char && !fits);
    assign wc_addr   = wr_base_reg + AW'(load_len_reg);
    assign len_data  = {ovf_after, len_after};

    always_comb
    begin
        state_next      = state_reg;
        stored_next     = stored_reg;
        wr_base_next    = wr_base_reg;
        load_len_next   = load_len_reg;
        load_ovf_next   = load_ovf_reg;
        qlen_next       = qlen_reg;
        qovf_next       = qovf_reg;
        dropped_next    = dropped_reg;
        slot_next       = slot_reg;
        base_next       = base_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        k_next          = k_reg;
        cnt_next        = cnt_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg && !pop;
        out_count_next  = out_count_reg;
        out_status_next = out_status_reg;
        cmd_pop         = 1'b0;
        wc_we           = 1'b0;
        len_we          = 1'b0;
        q_we            = 1'b0;
        advance         = 1'b0;

        case (state_reg)
            pswc_pkg::S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop = 1'b1;
                    case (cmd.op)
                        pswc_pkg::OP_LOAD:
                        begin
                            wc_we         = cmd.has_char && fits && room;
                            load_len_next = len_after;
                            load_ovf_next = ovf_after;
                            if (cmd.last)
                            begin
                                if (room)
                                begin
                                    len_we       = 1'b1;
                                    stored_next  = stored_reg + 1'b1;
                                    wr_base_next = wr_base_reg + AW'(MAX_LEN);
                                end
                                else
                                begin
                                    dropped_next = 1'b1;
                                end
                                load_len_next = '0;
                                load_ovf_next = 1'b0;
                            end
                        end
                        pswc_pkg::OP_QUERY, pswc_pkg::OP_SCAN:
                        begin
                            if (cmd.has_char)
                            begin
                                if (qlen_reg < LW'(MAX_LEN))
                                begin
                                    q_we      = 1'b1;
                                    qlen_next = qlen_reg + 1'b1;
                                end
                                else
                                begin
                                    qovf_next = 1'b1;
                                end
                            end
                            if (cmd.op == pswc_pkg::OP_SCAN)
                            begin
                                state_next = pswc_pkg::S_CHECK;
                            end
                        end
                        default:
                        begin
                            state_next = pswc_pkg::S_IDLE;
                        end
                    endcase
                end
            end
            pswc_pkg::S_CHECK:
            begin
                cnt_next        = '0;
                res_status_next = dropped_reg ? pswc_pkg::STATUS_DROPPED : pswc_pkg::STATUS_OK;
                if (qovf_reg)
                begin
                    res_status_next = pswc_pkg::STATUS_QUERY_LONG;
                    state_next      = pswc_pkg::S_POST;
                end
                else if (qlen_reg == '0 || stored_reg == '0)
                begin
                    state_next = pswc_pkg::S_POST;
                end
                else
                begin
                    slot_next  = '0;
                    base_next  = '0;
                    state_next = pswc_pkg::S_FETCH;
                end
            end
            pswc_pkg::S_FETCH:
            begin
                state_next = pswc_pkg::S_EVAL;
            end
            pswc_pkg::S_EVAL:
            begin
                if (rd_long || rd_len < qlen_reg)
                begin
                    advance = 1'b1;
                end
                else
                begin
                    head_next  = base_reg;
                    tail_next  = base_reg + AW'(rd_len - qlen_reg);
                    k_next     = '0;
                    state_next = pswc_pkg::S_READ;
                end
            end
            pswc_pkg::S_READ:
            begin
                state_next = pswc_pkg::S_CMP;
            end
            pswc_pkg::S_CMP:
            begin
                if (head_ch_reg != qry_ch_reg || tail_ch_reg != qry_ch_reg)
                begin
                    advance = 1'b1;
                end
                else if (k_reg + 1'b1 == qlen_reg)
                begin
                    if (cnt_reg != pswc_pkg::COUNT_MAX)
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                    advance = 1'b1;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    head_next  = head_reg + 1'b1;
                    tail_next  = tail_reg + 1'b1;
                    state_next = pswc_pkg::S_READ;
                end
            end
            pswc_pkg::S_POST:
            begin
                if (!out_valid_reg || pop)
                begin
                    out_valid_next  = 1'b1;
                    out_count_next  = cnt_reg;
                    out_status_next = res_status_reg;
                    qlen_next       = '0;
                    qovf_next       = 1'b0;
                    state_next      = pswc_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = pswc_pkg::S_IDLE;
            end
        endcase

        // move on to the next stored word, or finish the scan
        if (advance)
        begin
            slot_next = slot_reg + 1'b1;
            base_next = base_reg + AW'(MAX_LEN);
            if (slot_reg + 1'b1 == stored_reg)
            begin
                state_next = pswc_pkg::S_POST;
            end
            else
            begin
                state_next = pswc_pkg::S_FETCH;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= pswc_pkg::S_IDLE;
            stored_reg     <= '0;
            wr_base_reg    <= '0;
            load_len_reg   <= '0;
            load_ovf_reg   <= 1'b0;
            qlen_reg       <= '0;
            qovf_reg       <= 1'b0;
            dropped_reg    <= 1'b0;
            slot_reg       <= '0;
            base_reg       <= '0;
            head_reg       <= '0;
            tail_reg       <= '0;
            k_reg          <= '0;
            cnt_reg        <= '0;
            res_status_reg <= pswc_pkg::STATUS_OK;
            out_valid_reg  <= 1'b0;
            out_count_reg  <= '0;
            out_status_reg <= pswc_pkg::STATUS_OK;
        end
        else
        begin
            state_reg      <= state_next;
            stored_reg     <= stored_next;
            wr_base_reg    <= wr_base_next;
            load_len_reg   <= load_len_next;
            load_ovf_reg   <= load_ovf_next;
            qlen_reg       <= qlen_next;
            qovf_reg       <= qovf_next;
            dropped_reg    <= dropped_next;
            slot_reg       <= slot_next;
            base_reg       <= base_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            k_reg          <= k_next;
            cnt_reg        <= cnt_next;
            res_status_reg <= res_status_next;
            out_valid_reg  <= out_valid_next;
            out_count_reg  <= out_count_next;
            out_status_reg <= out_status_next;
        end
    end

    // word store: one write port, two read ports (head and tail of a word)
    always_ff @(posedge clk)
    begin
        if (wc_we)
        begin
            word_mem[wc_addr] <= cmd.ch;
        end
        head_ch_reg <= word_mem[head_reg];
        tail_ch_reg <= word_mem[tail_reg];
    end

    always_ff @(posedge clk)
    begin
        if (len_we)
        begin
            len_mem[stored_reg[SW-1:0]] <= len_data;
        end
        len_rd_reg <= len_mem[slot_reg[SW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (q_we)
        begin
            qry_mem[qlen_reg[QW-1:0]] <= cmd.ch;
        end
        qry_ch_reg <= qry_mem[k_reg[QW-1:0]];
    end

endmodule

>>> rtl/prefix_suffix_word_counter_unit.sv
// Top level of the prefix/suffix word counter: front queue plus scan back end.
// Loading characters and query characters are taken one per cycle unless the
// four-deep request queue is full, so input keeps going while the back end is
// busy. When a query ends, the back end scans the word store: S_CHECK, then
// S_FETCH and S_EVAL per stored word to read its length, plus S_READ and S_CMP
// per query character compared in words at least as long as the query (the
// compare stops at the first mismatch), then S_POST for the result. The scan
// rate is set by the single-character compare loop on the word store's two read
// ports. Results wait in a one-entry output register; a query end that finishes
// while it is still occupied holds the back end until the result is popped.
module prefix_suffix_word_counter_unit #(
    parameter int MAX_WORDS = pswc_pkg::MAX_WORDS_DEF,
    parameter int MAX_LEN   = pswc_pkg::MAX_LEN_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic                          action,
    input  logic [7:0]                    char_code,
    input  logic                          has_char,
    input  logic                          last,
    output logic                          empty,
    input  logic                          pop,
    output logic [pswc_pkg::COUNT_W-1:0]  match_count,
    output logic [1:0]                    status
);

    logic           cmd_valid;
    logic           cmd_pop;
    pswc_pkg::cmd_t cmd;

    pswc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .action    (action),
        .char_code (char_code),
        .has_char  (has_char),
        .last      (last),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop),
        .cmd       (cmd)
    );

    pswc_back #(
        .MAX_WORDS (MAX_WORDS),
        .MAX_LEN   (MAX_LEN)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_pop     (cmd_pop),
        .cmd         (cmd),
        .empty       (empty),
        .pop         (pop),
        .match_count (match_count),
        .status      (status)
    );

endmodule

>>> rtl/pswc_checker.sv
// Port-level checks for the prefix/suffix word counter, bound to the top level.
module pswc_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          empty,
    input logic                          pop,
    input logic [pswc_pkg::COUNT_W-1:0]  match_count,
    input logic [1:0]                    status
);

    // status code is always one of the three defined values
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (status == pswc_pkg::STATUS_OK || status == pswc_pkg::STATUS_QUERY_LONG
                    || status == pswc_pkg::STATUS_DROPPED))
        else $error("undefined status code");

    // an overlong query never reports matches
    a_long_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && status == pswc_pkg::STATUS_QUERY_LONG) |-> (match_count == '0))
        else $error("overlong query with nonzero count");

    // an unpopped result stays put
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(match_count) && $stable(status)))
        else $error("result changed before pop");

    // the result register only drains on a pop
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(empty) |-> $past(pop))
        else $error("result lost without pop");

endmodule

bind prefix_suffix_word_counter_unit pswc_checker u_pswc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .empty       (empty),
    .pop         (pop),
    .match_count (match_count),
    .status      (status)
);
